// File: rtl/sm83_dec_pkg.sv
// sm83_dec_pkg: shared types and codes for the sm83 instruction decoder
// holds the input and result word layouts, mnemonic, operand and condition codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sm83_dec_pkg;

    localparam logic [7:0] PREFIX_CB  = 8'hCB;
    localparam logic [7:0] OPC_HALT   = 8'h76;

    // mnemonic codes
    localparam logic [5:0] MN_NOP  = 6'd0;
    localparam logic [5:0] MN_LD   = 6'd1;
    localparam logic [5:0] MN_STOP = 6'd2;
    localparam logic [5:0] MN_JR   = 6'd3;
    localparam logic [5:0] MN_ADD  = 6'd4;
    localparam logic [5:0] MN_LDI  = 6'd5;
    localparam logic [5:0] MN_LDD  = 6'd6;
    localparam logic [5:0] MN_INC  = 6'd7;
    localparam logic [5:0] MN_DEC  = 6'd8;
    localparam logic [5:0] MN_RLCA = 6'd9;
    localparam logic [5:0] MN_HALT = 6'd17;
    localparam logic [5:0] MN_ADC  = 6'd18;
    localparam logic [5:0] MN_SUB  = 6'd19;
    localparam logic [5:0] MN_SBC  = 6'd20;
    localparam logic [5:0] MN_AND  = 6'd21;
    localparam logic [5:0] MN_XOR  = 6'd22;
    localparam logic [5:0] MN_OR   = 6'd23;
    localparam logic [5:0] MN_CP   = 6'd24;
    localparam logic [5:0] MN_RET  = 6'd25;
    localparam logic [5:0] MN_LDHL = 6'd26;
    localparam logic [5:0] MN_POP  = 6'd27;
    localparam logic [5:0] MN_RETI = 6'd28;
    localparam logic [5:0] MN_JP   = 6'd29;
    localparam logic [5:0] MN_DI   = 6'd30;
    localparam logic [5:0] MN_EI   = 6'd31;
    localparam logic [5:0] MN_CALL = 6'd32;
    localparam logic [5:0] MN_PUSH = 6'd33;
    localparam logic [5:0] MN_RST  = 6'd34;
    localparam logic [5:0] MN_RLC  = 6'd35;
    localparam logic [5:0] MN_SRL  = 6'd42;

    // operand codes
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_B     = 5'd1;
    localparam logic [4:0] OP_MHL   = 5'd7;
    localparam logic [4:0] OP_A     = 5'd8;
    localparam logic [4:0] OP_BC    = 5'd9;
    localparam logic [4:0] OP_HL    = 5'd11;
    localparam logic [4:0] OP_SP    = 5'd12;
    localparam logic [4:0] OP_AF    = 5'd13;
    localparam logic [4:0] OP_N     = 5'd14;
    localparam logic [4:0] OP_NN    = 5'd15;
    localparam logic [4:0] OP_MNN   = 5'd16;
    localparam logic [4:0] OP_MBC   = 5'd17;
    localparam logic [4:0] OP_MDE   = 5'd18;
    localparam logic [4:0] OP_HIGHN = 5'd19;
    localparam logic [4:0] OP_HIGHC = 5'd20;
    localparam logic [4:0] OP_REL   = 5'd21;

    localparam logic [2:0] COND_ALWAYS = 3'd4;

    typedef struct packed {
        logic [15:0] instr_pc;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  mnemonic;
        logic [4:0]  first_operand;
        logic [4:0]  second_operand;
        logic [2:0]  condition;
        logic [2:0]  bit_or_vector;
        logic [15:0] immediate;
        logic [1:0]  length;
        logic [15:0] branch_target;
        logic        prefixed;
        logic        illegal;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/sm83_dec_in_reg.sv
// sm83_dec_in_reg: input register stage of the sm83 decoder
// captures one instruction word and holds it until the result stage takes it
// depends on sm83_dec_pkg
`timescale 1ns / 1ps
`default_nettype none

module sm83_dec_in_reg
    import sm83_dec_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_word_t in_word,
    input  wire logic     down_ready,
    output logic          word_valid,
    output in_word_t      word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     take;

    assign in_stall = valid_reg && !down_ready;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// File: rtl/sm83_dec_logic.sv
// sm83_dec_logic: combinational decode of one instruction word
// splits the opcode into x/y/z/p/q fields, handles the cb page and jr target
// depends on sm83_dec_pkg
`timescale 1ns / 1ps
`default_nettype none

module sm83_dec_logic
    import sm83_dec_pkg::*;
(
    input  wire in_word_t word,
    output result_t       res
);

    logic [7:0]  op;
    logic [7:0]  b1;
    logic [1:0]  x;
    logic [2:0]  y;
    logic [2:0]  z;
    logic [1:0]  p;
    logic        q;
    logic [1:0]  cx;
    logic [2:0]  cy;
    logic [2:0]  cz;
    logic [15:0] imm8;
    logic [15:0] imm16;
    logic [15:0] jr_target;
    logic [4:0]  rp;
    logic [4:0]  rp2;
    logic [4:0]  mem_op;
    logic [5:0]  ld_mn;

    function automatic logic [5:0] alu_code(input logic [2:0] sel);
        logic [5:0] code;
        unique case (sel)
            3'd0:    code = MN_ADD;
            3'd1:    code = MN_ADC;
            3'd2:    code = MN_SUB;
            3'd3:    code = MN_SBC;
            3'd4:    code = MN_AND;
            3'd5:    code = MN_XOR;
            3'd6:    code = MN_OR;
            default: code = MN_CP;
        endcase
        return code;
    endfunction

    // add, adc and sbc name the accumulator first
    function automatic logic alu_acc(input logic [2:0] sel);
        return (sel == 3'd0) || (sel == 3'd1) || (sel == 3'd3);
    endfunction

    assign op    = word.first_byte;
    assign b1    = word.second_byte;
    assign x     = op[7:6];
    assign y     = op[5:3];
    assign z     = op[2:0];
    assign p     = op[5:4];
    assign q     = op[3];
    assign cx    = b1[7:6];
    assign cy    = b1[5:3];
    assign cz    = b1[2:0];
    assign imm8  = {8'h00, b1};
    assign imm16 = {word.third_byte, b1};
    assign rp    = OP_BC + 5'(p);
    assign rp2   = (p == 2'd3) ? OP_AF : rp;

    assign jr_target = word.instr_pc + 16'd2 + {{8{b1[7]}}, b1};

    always_comb
    begin
        unique case (p)
            2'd0:    begin mem_op = OP_MBC; ld_mn = MN_LD;  end
            2'd1:    begin mem_op = OP_MDE; ld_mn = MN_LD;  end
            2'd2:    begin mem_op = OP_MHL; ld_mn = MN_LDI; end
            default: begin mem_op = OP_MHL; ld_mn = MN_LDD; end
        endcase
    end

    always_comb
    begin
        res           = '0;
        res.condition = COND_ALWAYS;
        res.length    = 2'd1;
        if (op == PREFIX_CB)
        begin
            res.prefixed      = 1'b1;
            res.length        = 2'd2;
            res.first_operand = OP_B + 5'(cz);
            if (cx == 2'd0)
            begin
                res.mnemonic = MN_RLC + 6'(cy);
            end
            else
            begin
                res.mnemonic      = MN_SRL + 6'(cx);
                res.bit_or_vector = cy;
            end
        end
        else
        begin
            unique case (x)
                2'd1:
                begin
                    if (op == OPC_HALT)
                    begin
                        res.mnemonic = MN_HALT;
                    end
                    else
                    begin
                        res.mnemonic       = MN_LD;
                        res.first_operand  = OP_B + 5'(y);
                        res.second_operand = OP_B + 5'(z);
                    end
                end
                2'd2:
                begin
                    res.mnemonic = alu_code(y);
                    if (alu_acc(y))
                    begin
                        res.first_operand  = OP_A;
                        res.second_operand = OP_B + 5'(z);
                    end
                    else
                    begin
                        res.first_operand = OP_B + 5'(z);
                    end
                end
                2'd0:
                begin
                    unique case (z)
                        3'd0:
                        begin
                            priority case (y)
                                3'd0: res.mnemonic = MN_NOP;
                                3'd1:
                                begin
                                    res.mnemonic       = MN_LD;
                                    res.first_operand  = OP_MNN;
                                    res.second_operand = OP_SP;
                                    res.length         = 2'd3;
                                    res.immediate      = imm16;
                                end
                                3'd2:
                                begin
                                    res.mnemonic = MN_STOP;
                                    res.length   = 2'd2;
                                end
                                default:
                                begin
                                    res.mnemonic      = MN_JR;
                                    res.first_operand = OP_REL;
                                    res.length        = 2'd2;
                                    res.branch_target = jr_target;
                                    if (y[2])
                                    begin
                                        res.condition = {1'b0, y[1:0]};
                                    end
                                end
                            endcase
                        end
                        3'd1:
                        begin
                            if (!q)
                            begin
                                res.mnemonic       = MN_LD;
                                res.first_operand  = rp;
                                res.second_operand = OP_NN;
                                res.length         = 2'd3;
                                res.immediate      = imm16;
                            end
                            else
                            begin
                                res.mnemonic       = MN_ADD;
                                res.first_operand  = OP_HL;
                                res.second_operand = rp;
                            end
                        end
                        3'd2:
                        begin
                            res.mnemonic = ld_mn;
                            if (!q)
                            begin
                                res.first_operand  = mem_op;
                                res.second_operand = OP_A;
                            end
                            else
                            begin
                                res.first_operand  = OP_A;
                                res.second_operand = mem_op;
                            end
                        end
                        3'd3:
                        begin
                            res.mnemonic      = q ? MN_DEC : MN_INC;
                            res.first_operand = rp;
                        end
                        3'd4:
                        begin
                            res.mnemonic      = MN_INC;
                            res.first_operand = OP_B + 5'(y);
                        end
                        3'd5:
                        begin
                            res.mnemonic      = MN_DEC;
                            res.first_operand = OP_B + 5'(y);
                        end
                        3'd6:
                        begin
                            res.mnemonic       = MN_LD;
                            res.first_operand  = OP_B + 5'(y);
                            res.second_operand = OP_N;
                            res.length         = 2'd2;
                            res.immediate      = imm8;
                        end
                        default:
                        begin
                            res.mnemonic = MN_RLCA + 6'(y);
                        end
                    endcase
                end
                default:
                begin
                    unique case (z)
                        3'd0:
                        begin
                            if (!y[2])
                            begin
                                res.mnemonic  = MN_RET;
                                res.condition = {1'b0, y[1:0]};
                            end
                            else
                            begin
                                res.length    = 2'd2;
                                res.immediate = imm8;
                                unique case (y[1:0])
                                    2'd0:
                                    begin
                                        res.mnemonic       = MN_LD;
                                        res.first_operand  = OP_HIGHN;
                                        res.second_operand = OP_A;
                                    end
                                    2'd1:
                                    begin
                                        res.mnemonic       = MN_ADD;
                                        res.first_operand  = OP_SP;
                                        res.second_operand = OP_N;
                                    end
                                    2'd2:
                                    begin
                                        res.mnemonic       = MN_LD;
                                        res.first_operand  = OP_A;
                                        res.second_operand = OP_HIGHN;
                                    end
                                    default:
                                    begin
                                        res.mnemonic       = MN_LDHL;
                                        res.first_operand  = OP_SP;
                                        res.second_operand = OP_N;
                                    end
                                endcase
                            end
                        end
                        3'd1:
                        begin
                            if (!q)
                            begin
                                res.mnemonic      = MN_POP;
                                res.first_operand = rp2;
                            end
                            else
                            begin
                                unique case (p)
                                    2'd0: res.mnemonic = MN_RET;
                                    2'd1: res.mnemonic = MN_RETI;
                                    2'd2:
                                    begin
                                        res.mnemonic      = MN_JP;
                                        res.first_operand = OP_HL;
                                    end
                                    default:
                                    begin
                                        res.mnemonic       = MN_LD;
                                        res.first_operand  = OP_SP;
                                        res.second_operand = OP_HL;
                                    end
                                endcase
                            end
                        end
                        3'd2:
                        begin
                            if (!y[2])
                            begin
                                res.mnemonic      = MN_JP;
                                res.first_operand = OP_NN;
                                res.condition     = {1'b0, y[1:0]};
                                res.length        = 2'd3;
                                res.immediate     = imm16;
                            end
                            else
                            begin
                                res.mnemonic = MN_LD;
                                unique case (y[1:0])
                                    2'd0:
                                    begin
                                        res.first_operand  = OP_HIGHC;
                                        res.second_operand = OP_A;
                                    end
                                    2'd1:
                                    begin
                                        res.first_operand  = OP_MNN;
                                        res.second_operand = OP_A;
                                        res.length         = 2'd3;
                                        res.immediate      = imm16;
                                    end
                                    2'd2:
                                    begin
                                        res.first_operand  = OP_A;
                                        res.second_operand = OP_HIGHC;
                                    end
                                    default:
                                    begin
                                        res.first_operand  = OP_A;
                                        res.second_operand = OP_MNN;
                                        res.length         = 2'd3;
                                        res.immediate      = imm16;
                                    end
                                endcase
                            end
                        end
                        3'd3:
                        begin
                            priority case (y)
                                3'd0:
                                begin
                                    res.mnemonic      = MN_JP;
                                    res.first_operand = OP_NN;
                                    res.length        = 2'd3;
                                    res.immediate     = imm16;
                                end
                                3'd6:    res.mnemonic = MN_DI;
                                3'd7:    res.mnemonic = MN_EI;
                                default: res.illegal  = 1'b1;
                            endcase
                        end
                        3'd4:
                        begin
                            if (!y[2])
                            begin
                                res.mnemonic      = MN_CALL;
                                res.first_operand = OP_NN;
                                res.condition     = {1'b0, y[1:0]};
                                res.length        = 2'd3;
                                res.immediate     = imm16;
                            end
                            else
                            begin
                                res.illegal = 1'b1;
                            end
                        end
                        3'd5:
                        begin
                            if (!q)
                            begin
                                res.mnemonic      = MN_PUSH;
                                res.first_operand = rp2;
                            end
                            else if (p == 2'd0)
                            begin
                                res.mnemonic      = MN_CALL;
                                res.first_operand = OP_NN;
                                res.length        = 2'd3;
                                res.immediate     = imm16;
                            end
                            else
                            begin
                                res.illegal = 1'b1;
                            end
                        end
                        3'd6:
                        begin
                            res.mnemonic  = alu_code(y);
                            res.length    = 2'd2;
                            res.immediate = imm8;
                            if (alu_acc(y))
                            begin
                                res.first_operand  = OP_A;
                                res.second_operand = OP_N;
                            end
                            else
                            begin
                                res.first_operand = OP_N;
                            end
                        end
                        default:
                        begin
                            res.mnemonic      = MN_RST;
                            res.bit_or_vector = y;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/sm83_dec_out_reg.sv
// sm83_dec_out_reg: result register stage of the sm83 decoder
// holds one decoded word until the consumer takes it
// depends on sm83_dec_pkg
`timescale 1ns / 1ps
`default_nettype none

module sm83_dec_out_reg
    import sm83_dec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res_word,
    output logic         res_ready,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;
    logic    load;

    assign res_ready = !valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= res_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// File: rtl/sm83_instruction_decoder_core.sv
// sm83_instruction_decoder_core: top level of the sm83 instruction decoder
// joins the input register, the decode logic and the result register
// depends on sm83_dec_pkg, sm83_dec_in_reg, sm83_dec_logic, sm83_dec_out_reg
//
// Decodes one instruction word (address plus three fetched bytes) per clock
// while the output is not stalled. An accepted word is held in the input
// register, where the whole decode and the 16-bit relative target add run,
// and its result is then captured in the result register, which drives the
// output until the consumer takes it. Both stages hold a word each, so the
// input keeps taking words while a result waits; the input stalls only when
// both registers are full and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module sm83_instruction_decoder_core
    import sm83_dec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] instr_pc,
    input  wire logic [7:0]  first_byte,
    input  wire logic [7:0]  second_byte,
    input  wire logic [7:0]  third_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       mnemonic,
    output logic [4:0]       first_operand,
    output logic [4:0]       second_operand,
    output logic [2:0]       condition,
    output logic [2:0]       bit_or_vector,
    output logic [15:0]      immediate,
    output logic [1:0]       length,
    output logic [15:0]      branch_target,
    output logic             prefixed,
    output logic             illegal
);

    in_word_t in_word;
    in_word_t word;
    logic     word_valid;
    logic     res_ready;
    result_t  res_word;
    result_t  out_word;

    assign in_word.instr_pc    = instr_pc;
    assign in_word.first_byte  = first_byte;
    assign in_word.second_byte = second_byte;
    assign in_word.third_byte  = third_byte;

    sm83_dec_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .down_ready (res_ready),
        .word_valid (word_valid),
        .word       (word)
    );

    sm83_dec_logic u_logic (
        .word (word),
        .res  (res_word)
    );

    sm83_dec_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (word_valid),
        .res_word  (res_word),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign mnemonic       = out_word.mnemonic;
    assign first_operand  = out_word.first_operand;
    assign second_operand = out_word.second_operand;
    assign condition      = out_word.condition;
    assign bit_or_vector  = out_word.bit_or_vector;
    assign immediate      = out_word.immediate;
    assign length         = out_word.length;
    assign branch_target  = out_word.branch_target;
    assign prefixed       = out_word.prefixed;
    assign illegal        = out_word.illegal;

    // input only backs up when the result register is full
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result register");

    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length != 2'd0)
        else $error("zero instruction length");

    a_illegal_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && illegal) |-> (mnemonic == MN_NOP && condition == COND_ALWAYS
            && length == 2'd1 && !prefixed))
        else $error("illegal opcode with decoded fields");

    a_target_only_jr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mnemonic != MN_JR) |-> branch_target == 16'd0)
        else $error("branch target on a non relative instruction");

    a_prefix_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && prefixed) |-> (length == 2'd2 && !illegal))
        else $error("prefixed word with wrong length");

endmodule

`default_nettype wire

// File: tb/sm83_instruction_decoder_core_tb.sv
// sm83_instruction_decoder_core_tb: self-checking bench for the sm83 instruction decoder
// directed table, full opcode sweeps and random words, checked against a decode predictor
// depends on sm83_dec_pkg and sm83_instruction_decoder_core
`timescale 1ns / 1ps

module sm83_instruction_decoder_core_tb;
    import sm83_dec_pkg::*;

    localparam logic [5:0] MN_SET      = 6'd45;
    localparam logic [2:0] COND_NZ     = 3'd0;
    localparam logic [2:0] COND_C      = 3'd3;
    localparam int         HOLD_CYCLES = 40;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         DRAIN_WAIT  = 8;
    localparam int         SWEEP_SIZE  = 256;
    localparam int         RAND_WORDS  = 340;

    typedef struct {
        in_word_t w;
        bit       known;
        result_t  r;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] instr_pc = '0;
    logic [7:0]  first_byte = '0;
    logic [7:0]  second_byte = '0;
    logic [7:0]  third_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  mnemonic;
    logic [4:0]  first_operand;
    logic [4:0]  second_operand;
    logic [2:0]  condition;
    logic [2:0]  bit_or_vector;
    logic [15:0] immediate;
    logic [1:0]  length;
    logic [15:0] branch_target;
    logic        prefixed;
    logic        illegal;

    result_t     pending_decodes[$];
    dir_row_t    dir_tab[$];
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    sm83_instruction_decoder_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .instr_pc       (instr_pc),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .third_byte     (third_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mnemonic       (mnemonic),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .condition      (condition),
        .bit_or_vector  (bit_or_vector),
        .immediate      (immediate),
        .length         (length),
        .branch_target  (branch_target),
        .prefixed       (prefixed),
        .illegal        (illegal)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [4:0] r8_operand(logic [2:0] idx);
        return {2'b00, idx} + 5'd1;
    endfunction

    function automatic logic [4:0] rp2_operand(logic [1:0] p);
        if (p == 2'd3)
            return OP_AF;
        return OP_BC + {3'b000, p};
    endfunction

    function automatic result_t alu_form(result_t r, logic [2:0] y, logic [4:0] src);
        case (y)
            3'd0: r.mnemonic = MN_ADD;
            3'd1: r.mnemonic = MN_ADC;
            3'd2: r.mnemonic = MN_SUB;
            3'd3: r.mnemonic = MN_SBC;
            3'd4: r.mnemonic = MN_AND;
            3'd5: r.mnemonic = MN_XOR;
            3'd6: r.mnemonic = MN_OR;
            default: r.mnemonic = MN_CP;
        endcase
        // accumulator forms keep A first, the others name only the source
        if (y == 3'd0 || y == 3'd1 || y == 3'd3)
        begin
            r.first_operand = OP_A;
            r.second_operand = src;
        end
        else
        begin
            r.first_operand = src;
        end
        return r;
    endfunction

    function automatic result_t decode_instr(in_word_t w);
        result_t     r;
        logic [7:0]  op;
        logic [1:0]  x;
        logic [1:0]  p;
        logic [2:0]  y;
        logic [2:0]  z;
        logic        q;
        logic [15:0] imm16;
        r = '0;
        r.condition = COND_ALWAYS;
        r.length = 2'd1;
        imm16 = {w.third_byte, w.second_byte};
        if (w.first_byte == PREFIX_CB)
        begin
            op = w.second_byte;
            x = op[7:6];
            y = op[5:3];
            z = op[2:0];
            r.prefixed = 1'b1;
            r.length = 2'd2;
            r.first_operand = r8_operand(z);
            if (x == 2'd0)
                r.mnemonic = MN_RLC + {3'b000, y};
            else
            begin
                r.mnemonic = MN_SRL + {4'b0000, x};
                r.bit_or_vector = y;
            end
            return r;
        end
        op = w.first_byte;
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        p = op[5:4];
        q = op[3];
        if (x == 2'd1)
        begin
            if (op == OPC_HALT)
                r.mnemonic = MN_HALT;
            else
            begin
                r.mnemonic = MN_LD;
                r.first_operand = r8_operand(y);
                r.second_operand = r8_operand(z);
            end
        end
        else if (x == 2'd2)
        begin
            r = alu_form(r, y, r8_operand(z));
        end
        else if (x == 2'd0)
        begin
            case (z)
                3'd0:
                begin
                    if (y == 3'd0)
                        r.mnemonic = MN_NOP;
                    else if (y == 3'd1)
                    begin
                        r.mnemonic = MN_LD;
                        r.first_operand = OP_MNN;
                        r.second_operand = OP_SP;
                        r.length = 2'd3;
                        r.immediate = imm16;
                    end
                    else if (y == 3'd2)
                    begin
                        r.mnemonic = MN_STOP;
                        r.length = 2'd2;
                    end
                    else
                    begin
                        r.mnemonic = MN_JR;
                        r.first_operand = OP_REL;
                        r.length = 2'd2;
                        if (y >= 3'd4)
                            r.condition = y - 3'd4;
                        r.branch_target = w.instr_pc + 16'd2
                            + {{8{w.second_byte[7]}}, w.second_byte};
                    end
                end
                3'd1:
                begin
                    if (!q)
                    begin
                        r.mnemonic = MN_LD;
                        r.first_operand = OP_BC + {3'b000, p};
                        r.second_operand = OP_NN;
                        r.length = 2'd3;
                        r.immediate = imm16;
                    end
                    else
                    begin
                        r.mnemonic = MN_ADD;
                        r.first_operand = OP_HL;
                        r.second_operand = OP_BC + {3'b000, p};
                    end
                end
                3'd2:
                begin
                    logic [4:0] mem;
                    mem = (p == 2'd0) ? OP_MBC : (p == 2'd1) ? OP_MDE : OP_MHL;
                    r.mnemonic = (p == 2'd2) ? MN_LDI : (p == 2'd3) ? MN_LDD : MN_LD;
                    if (!q)
                    begin
                        r.first_operand = mem;
                        r.second_operand = OP_A;
                    end
                    else
                    begin
                        r.first_operand = OP_A;
                        r.second_operand = mem;
                    end
                end
                3'd3:
                begin
                    r.mnemonic = q ? MN_DEC : MN_INC;
                    r.first_operand = OP_BC + {3'b000, p};
                end
                3'd4:
                begin
                    r.mnemonic = MN_INC;
                    r.first_operand = r8_operand(y);
                end
                3'd5:
                begin
                    r.mnemonic = MN_DEC;
                    r.first_operand = r8_operand(y);
                end
                3'd6:
                begin
                    r.mnemonic = MN_LD;
                    r.first_operand = r8_operand(y);
                    r.second_operand = OP_N;
                    r.length = 2'd2;
                    r.immediate = {8'h00, w.second_byte};
                end
                default:
                begin
                    r.mnemonic = MN_RLCA + {3'b000, y};
                end
            endcase
        end
        else
        begin
            case (z)
                3'd0:
                begin
                    if (y < 3'd4)
                    begin
                        r.mnemonic = MN_RET;
                        r.condition = y;
                    end
                    else
                    begin
                        r.length = 2'd2;
                        r.immediate = {8'h00, w.second_byte};
                        case (y)
                            3'd4:
                            begin
                                r.mnemonic = MN_LD;
                                r.first_operand = OP_HIGHN;
                                r.second_operand = OP_A;
                            end
                            3'd5:
                            begin
                                r.mnemonic = MN_ADD;
                                r.first_operand = OP_SP;
                                r.second_operand = OP_N;
                            end
                            3'd6:
                            begin
                                r.mnemonic = MN_LD;
                                r.first_operand = OP_A;
                                r.second_operand = OP_HIGHN;
                            end
                            default:
                            begin
                                r.mnemonic = MN_LDHL;
                                r.first_operand = OP_SP;
                                r.second_operand = OP_N;
                            end
                        endcase
                    end
                end
                3'd1:
                begin
                    if (!q)
                    begin
                        r.mnemonic = MN_POP;
                        r.first_operand = rp2_operand(p);
                    end
                    else if (p == 2'd0)
                        r.mnemonic = MN_RET;
                    else if (p == 2'd1)
                        r.mnemonic = MN_RETI;
                    else if (p == 2'd2)
                    begin
                        r.mnemonic = MN_JP;
                        r.first_operand = OP_HL;
                    end
                    else
                    begin
                        r.mnemonic = MN_LD;
                        r.first_operand = OP_SP;
                        r.second_operand = OP_HL;
                    end
                end
                3'd2:
                begin
                    if (y == 3'd4 || y == 3'd6)
                    begin
                        r.mnemonic = MN_LD;
                        r.first_operand = (y == 3'd4) ? OP_HIGHC : OP_A;
                        r.second_operand = (y == 3'd4) ? OP_A : OP_HIGHC;
                    end
                    else
                    begin
                        r.length = 2'd3;
                        r.immediate = imm16;
                        if (y < 3'd4)
                        begin
                            r.mnemonic = MN_JP;
                            r.first_operand = OP_NN;
                            r.condition = y;
                        end
                        else
                        begin
                            r.mnemonic = MN_LD;
                            r.first_operand = (y == 3'd5) ? OP_MNN : OP_A;
                            r.second_operand = (y == 3'd5) ? OP_A : OP_MNN;
                        end
                    end
                end
                3'd3:
                begin
                    if (y == 3'd0)
                    begin
                        r.mnemonic = MN_JP;
                        r.first_operand = OP_NN;
                        r.length = 2'd3;
                        r.immediate = imm16;
                    end
                    else if (y == 3'd6)
                        r.mnemonic = MN_DI;
                    else if (y == 3'd7)
                        r.mnemonic = MN_EI;
                    else
                        r.illegal = 1'b1;
                end
                3'd4:
                begin
                    if (y < 3'd4)
                    begin
                        r.mnemonic = MN_CALL;
                        r.first_operand = OP_NN;
                        r.condition = y;
                        r.length = 2'd3;
                        r.immediate = imm16;
                    end
                    else
                        r.illegal = 1'b1;
                end
                3'd5:
                begin
                    if (!q)
                    begin
                        r.mnemonic = MN_PUSH;
                        r.first_operand = rp2_operand(p);
                    end
                    else if (p == 2'd0)
                    begin
                        r.mnemonic = MN_CALL;
                        r.first_operand = OP_NN;
                        r.length = 2'd3;
                        r.immediate = imm16;
                    end
                    else
                        r.illegal = 1'b1;
                end
                3'd6:
                begin
                    r = alu_form(r, y, OP_N);
                    r.length = 2'd2;
                    r.immediate = {8'h00, w.second_byte};
                end
                default:
                begin
                    r.mnemonic = MN_RST;
                    r.bit_or_vector = y;
                end
            endcase
        end
        return r;
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        w.instr_pc = 16'($urandom_range(0, 65535));
        w.first_byte = 8'($urandom_range(0, 255));
        w.second_byte = 8'($urandom_range(0, 255));
        w.third_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic row_pred(logic [15:0] pc, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        dir_row_t row;
        row.w = {pc, b0, b1, b2};
        row.known = 1'b0;
        row.r = '0;
        dir_tab.insert(dir_tab.size(), row);
    endtask

    task automatic row_known(logic [15:0] pc, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             logic [5:0] mn, logic [4:0] a, logic [4:0] b,
                             logic [2:0] cond, logic [2:0] bitv, logic [15:0] imm,
                             logic [1:0] len, logic [15:0] tgt, logic pre, logic ill);
        dir_row_t row;
        row.w = {pc, b0, b1, b2};
        row.known = 1'b1;
        row.r = {mn, a, b, cond, bitv, imm, len, tgt, pre, ill};
        dir_tab.insert(dir_tab.size(), row);
    endtask

    task automatic send_word(in_word_t w, result_t exp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instr_pc <= w.instr_pc;
        first_byte <= w.first_byte;
        second_byte <= w.second_byte;
        third_byte <= w.third_byte;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_decodes.insert(pending_decodes.size(), exp);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(string what, int unsigned exp, int unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp, got);
    endtask

    task automatic check_field(string what, int unsigned exp, int unsigned got);
        if (exp != got)
            note_mismatch(what, exp, got);
    endtask

    // receiver side: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else if (out_valid && !out_stall)
            begin
                if (pending_decodes.size() == 0)
                    note_mismatch("unexpected word, mnemonic", 0, mnemonic);
                else
                begin
                    exp = pending_decodes.pop_front();
                    check_field("mnemonic", exp.mnemonic, mnemonic);
                    check_field("first_operand", exp.first_operand, first_operand);
                    check_field("second_operand", exp.second_operand, second_operand);
                    check_field("condition", exp.condition, condition);
                    check_field("bit_or_vector", exp.bit_or_vector, bit_or_vector);
                    check_field("immediate", exp.immediate, immediate);
                    check_field("length", exp.length, length);
                    check_field("branch_target", exp.branch_target, branch_target);
                    check_field("prefixed", exp.prefixed, prefixed);
                    check_field("illegal", exp.illegal, illegal);
                end
            end
        end
    end

    initial
    begin
        in_word_t w;
        result_t  exp;

        // extremes, illegal opcodes, prefix page, relative jumps with wrap
        row_known(16'h0000, 8'h00, 8'h00, 8'h00, MN_NOP, OP_NONE, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd1, 16'h0000, 1'b0, 1'b0);
        row_known(16'hFFFF, OPC_HALT, 8'hFF, 8'hFF, MN_HALT, OP_NONE, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd1, 16'h0000, 1'b0, 1'b0);
        row_known(16'h0000, 8'hD3, 8'hFF, 8'hFF, MN_NOP, OP_NONE, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd1, 16'h0000, 1'b0, 1'b1);
        row_known(16'hFFFF, 8'hFD, 8'h00, 8'h00, MN_NOP, OP_NONE, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd1, 16'h0000, 1'b0, 1'b1);
        row_known(16'h4000, PREFIX_CB, 8'h00, 8'hFF, MN_RLC, OP_B, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd2, 16'h0000, 1'b1, 1'b0);
        row_known(16'hFFFF, PREFIX_CB, 8'hFF, 8'hFF, MN_SET, OP_A, OP_NONE, COND_ALWAYS,
                  3'd7, 16'h0000, 2'd2, 16'h0000, 1'b1, 1'b0);
        row_known(16'hFFFF, 8'h18, 8'h7F, 8'hFF, MN_JR, OP_REL, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd2, 16'h0080, 1'b0, 1'b0);
        row_known(16'h0000, 8'h20, 8'h80, 8'h00, MN_JR, OP_REL, OP_NONE, COND_NZ,
                  3'd0, 16'h0000, 2'd2, 16'hFF82, 1'b0, 1'b0);
        row_known(16'h1234, 8'h38, 8'hFE, 8'h11, MN_JR, OP_REL, OP_NONE, COND_C,
                  3'd0, 16'h0000, 2'd2, 16'h1234, 1'b0, 1'b0);
        row_known(16'h8000, 8'h01, 8'hFF, 8'hFF, MN_LD, OP_BC, OP_NN, COND_ALWAYS,
                  3'd0, 16'hFFFF, 2'd3, 16'h0000, 1'b0, 1'b0);
        row_known(16'h0100, 8'h08, 8'h00, 8'h00, MN_LD, OP_MNN, OP_SP, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd3, 16'h0000, 1'b0, 1'b0);
        row_known(16'h0150, 8'h10, 8'hAA, 8'h55, MN_STOP, OP_NONE, OP_NONE, COND_ALWAYS,
                  3'd0, 16'h0000, 2'd2, 16'h0000, 1'b0, 1'b0);
        row_pred(16'h2000, 8'h22, 8'h00, 8'h00);
        row_pred(16'h2001, 8'h3A, 8'hFF, 8'hFF);
        row_pred(16'h2002, 8'hC6, 8'h80, 8'h01);
        row_pred(16'h2003, 8'h90, 8'h00, 8'h00);
        row_pred(16'h2004, 8'hFE, 8'h7F, 8'h00);
        row_pred(16'h2005, 8'hFF, 8'hFF, 8'hFF);
        row_pred(16'h2006, 8'hF5, 8'h00, 8'h00);
        row_pred(16'h2007, 8'hF1, 8'h00, 8'h00);
        row_pred(16'h2008, 8'hE0, 8'hFF, 8'h00);
        row_pred(16'h2009, 8'hF2, 8'h00, 8'h00);
        row_pred(16'h200A, 8'hCC, 8'h34, 8'h12);
        row_pred(16'h200B, 8'hF8, 8'h80, 8'h00);
        row_pred(16'h200C, PREFIX_CB, 8'h86, 8'h00);

        send_idle_pct = 19;
        recv_stall_pct = 79;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            exp = dir_tab[i].known ? dir_tab[i].r : decode_instr(dir_tab[i].w);
            send_word(dir_tab[i].w, exp);
        end

        // every opcode of the main page with random operand bytes
        for (int op = 0; op < SWEEP_SIZE; op++)
        begin
            w = rand_word();
            w.first_byte = op[7:0];
            send_word(w, decode_instr(w));
        end
        drain();

        // every opcode of the prefix page
        send_idle_pct = 79;
        recv_stall_pct = 19;
        for (int op = 0; op < SWEEP_SIZE; op++)
        begin
            w = rand_word();
            w.first_byte = PREFIX_CB;
            w.second_byte = op[7:0];
            send_word(w, decode_instr(w));
        end
        drain();

        // back-to-back words; a long output hold-off fills the pipe
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            w = rand_word();
            if ($urandom_range(0, 7) == 0)
                w.first_byte = PREFIX_CB;
            send_word(w, decode_instr(w));
        end
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && pending_decodes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
